// File: hdl/hufd_pkg.sv
// hufd_pkg: request codes, transaction structs and shared constants for the
// bit-serial Huffman table decoder. No dependencies.
package hufd_pkg;

  // Request codes
  localparam logic [1:0] REQ_LOAD   = 2'd0;
  localparam logic [1:0] REQ_DECODE = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;

  // Table cells per priority group
  localparam int GROUP_SIZE = 16;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  entry_index;
    logic [7:0]  entry_symbol;
    logic [15:0] entry_code;
    logic [4:0]  entry_length;
    logic [7:0]  code_byte;
    logic [3:0]  bit_count;
  } request_t;

  typedef struct packed {
    logic [7:0] symbol;
    logic       overflow;
    logic       last_of_item;
  } result_t;

  // One code table entry as held by a cell
  typedef struct packed {
    logic [7:0]  symbol;
    logic [15:0] code;
    logic [4:0]  length;
  } cell_entry_t;

endpackage

// File: hdl/huffman_table_decoder.sv
// huffman_table_decoder: top level; row of table cells, grouped priority
// select and the bit sequencer. Depends on hufd_pkg, hufd_cell, hufd_pick.
//
//  channel  | signals                  | handshake
//  ---------+--------------------------+------------------------------------
//  request  | start, busy, request     | taken on start high and busy low
//  result   | valid, result            | one-cycle strobe, always taken
//
// Load and clear leave busy low.
// Decode: each bit passes through shift, cell compare, group select and
// final select, then a flush step delivers the closing result when one is
// held; the priority select across all cells is split over the group and
// final select steps.
// Reset (rst, synchronous) clears the accumulator and sequencer; table
// entries hold garbage until loaded.
module huffman_table_decoder import hufd_pkg::*; #(
  parameter int TABLE_ENTRIES = 256,
  parameter int MAX_CODE_LEN  = 16
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  request_t request,
  output logic     valid,
  output result_t  result
);

  localparam int AW = MAX_CODE_LEN;
  localparam int LW = $clog2(MAX_CODE_LEN + 1);
  localparam int NG = (TABLE_ENTRIES + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int NC = NG * GROUP_SIZE;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SHIFT = 3'd1;
  localparam logic [2:0] S_CMP   = 3'd2;
  localparam logic [2:0] S_GRP   = 3'd3;
  localparam logic [2:0] S_SEL   = 3'd4;
  localparam logic [2:0] S_FLUSH = 3'd5;

  logic [2:0]               state;
  logic [AW-1:0]            acc;
  logic [LW-1:0]            acc_len;
  logic [7:0]               bits;
  logic [3:0]               remain;
  logic                     pend_valid;
  logic [7:0]               pend_sym;
  logic                     pend_ovf;

  logic                     accept;
  logic                     load_we;
  cell_entry_t              entry;
  logic [NC-1:0]            cell_hit;
  logic [NC-1:0][7:0]       cell_sym;
  logic [NG-1:0]            grp_hit_next;
  logic [NG-1:0][7:0]       grp_sym_next;
  logic [NG-1:0]            grp_hit;
  logic [NG-1:0][7:0]       grp_sym;
  logic                     f_hit;
  logic [7:0]               f_sym;
  logic                     ovf_now;

  assign busy    = (state != S_IDLE);
  assign accept  = start && !busy;
  assign load_we = accept && (request.req_type == REQ_LOAD);
  assign entry   = '{symbol: request.entry_symbol, code: request.entry_code,
                     length: request.entry_length};

  // Row of table cells; padding cells never hit
  for (genvar i = 0; i < NC; i++) begin : g_cell
    if (i < TABLE_ENTRIES) begin : g_real
      hufd_cell #(.MAX_CODE_LEN(MAX_CODE_LEN)) u_cell (
        .clk     (clk),
        .write   (load_we && (request.entry_index == 8'(i))),
        .entry   (entry),
        .acc     (acc),
        .acc_len (acc_len),
        .hit     (cell_hit[i]),
        .symbol  (cell_sym[i])
      );
    end else begin : g_pad
      assign cell_hit[i] = 1'b0;
      assign cell_sym[i] = 8'd0;
    end
  end

  // First level of the priority select, one per group of cells
  for (genvar g = 0; g < NG; g++) begin : g_grp
    hufd_pick #(.N(GROUP_SIZE)) u_pick (
      .hit       (cell_hit[g*GROUP_SIZE +: GROUP_SIZE]),
      .sym       (cell_sym[g*GROUP_SIZE +: GROUP_SIZE]),
      .any_hit   (grp_hit_next[g]),
      .first_sym (grp_sym_next[g])
    );
  end

  always_ff @(posedge clk) begin
    grp_hit <= grp_hit_next;
    grp_sym <= grp_sym_next;
  end

  // Final level across groups
  hufd_pick #(.N(NG)) u_final (
    .hit       (grp_hit),
    .sym       (grp_sym),
    .any_hit   (f_hit),
    .first_sym (f_sym)
  );

  assign ovf_now = !f_hit && (acc_len == LW'(MAX_CODE_LEN));

  // Sequencer: one bit per pass through shift, compare, group, select
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      acc        <= '0;
      acc_len    <= '0;
      remain     <= 4'd0;
      pend_valid <= 1'b0;
      valid      <= 1'b0;
    end else begin
      valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (request.req_type)
              REQ_DECODE: begin
                bits   <= request.code_byte;
                remain <= (request.bit_count > 4'd8) ? 4'd8 : request.bit_count;
                if (request.bit_count != 4'd0) begin
                  state <= S_SHIFT;
                end
              end
              REQ_CLEAR: begin
                acc     <= '0;
                acc_len <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        S_SHIFT: begin
          acc     <= AW'({acc, bits[7]});
          acc_len <= acc_len + 1'b1;
          bits    <= {bits[6:0], 1'b0};
          remain  <= remain - 4'd1;
          state   <= S_CMP;
        end
        S_CMP: begin
          state <= S_GRP;
        end
        S_GRP: begin
          state <= S_SEL;
        end
        S_SEL: begin
          // a new result releases the held one as not last
          if (f_hit || ovf_now) begin
            if (pend_valid) begin
              valid  <= 1'b1;
              result <= '{symbol: pend_sym, overflow: pend_ovf, last_of_item: 1'b0};
            end
            pend_valid <= 1'b1;
            pend_sym   <= f_hit ? f_sym : 8'd0;
            pend_ovf   <= !f_hit;
            acc        <= '0;
            acc_len    <= '0;
          end
          if (remain == 4'd0) begin
            state <= (pend_valid || f_hit || ovf_now) ? S_FLUSH : S_IDLE;
          end else begin
            state <= S_SHIFT;
          end
        end
        S_FLUSH: begin
          valid      <= 1'b1;
          result     <= '{symbol: pend_sym, overflow: pend_ovf, last_of_item: 1'b1};
          pend_valid <= 1'b0;
          state      <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  // results leave only from the select or flush steps
  a_valid_src: assert property (@(posedge clk) disable iff (rst)
    valid |-> ($past(state) == S_SEL || $past(state) == S_FLUSH))
    else $error("result strobe outside select or flush");

  // flush always delivers the closing result of a decode
  a_flush_last: assert property (@(posedge clk) disable iff (rst)
    state == S_FLUSH |=> valid && result.last_of_item)
    else $error("flush did not deliver a last result");

  // accumulator never holds more than the maximum code length
  a_len_max: assert property (@(posedge clk) disable iff (rst)
    acc_len <= LW'(MAX_CODE_LEN))
    else $error("accumulated length past maximum");

  // overflow results carry a zero symbol
  a_ovf_sym: assert property (@(posedge clk) disable iff (rst)
    valid && result.overflow |-> result.symbol == 8'd0)
    else $error("overflow result with nonzero symbol");
`endif

endmodule

// File: hdl/hufd_cell.sv
// hufd_cell: one code table entry with its own comparator against the
// shared bit accumulator. Depends on hufd_pkg.
module hufd_cell import hufd_pkg::*; #(
  parameter int MAX_CODE_LEN = 16
) (
  input  logic                               clk,
  input  logic                               write,
  input  cell_entry_t                        entry,
  input  logic [MAX_CODE_LEN-1:0]            acc,
  input  logic [$clog2(MAX_CODE_LEN+1)-1:0]  acc_len,
  output logic                               hit,
  output logic [7:0]                         symbol
);

  localparam int CW = (MAX_CODE_LEN > 16) ? MAX_CODE_LEN : 16;
  localparam logic [5:0] MAXL = 6'(MAX_CODE_LEN);

  cell_entry_t   stored;
  logic [CW-1:0] code_ext;
  logic [CW-1:0] acc_ext;
  logic [CW-1:0] mask;
  logic          len_ok;
  logic          hit_next;

  // Entry storage, written by a load transaction
  always_ff @(posedge clk) begin
    if (write) begin
      stored <= entry;
    end
  end

  // Length must be used, in range and equal to the accumulated length;
  // only the low length bits of the stored code take part
  always_comb begin
    code_ext = CW'(stored.code);
    acc_ext  = CW'(acc);
    mask     = ~({CW{1'b1}} << stored.length);
    len_ok   = (stored.length != 5'd0) && ({1'b0, stored.length} <= MAXL) &&
               ({1'b0, stored.length} == 6'(acc_len));
    hit_next = len_ok && ((code_ext & mask) == acc_ext);
  end

  always_ff @(posedge clk) begin
    hit <= hit_next;
  end

  assign symbol = stored.symbol;

endmodule

// File: hdl/hufd_pick.sv
// hufd_pick: lowest-index priority select over a row of hit flags and
// symbols. Depends on hufd_pkg.
module hufd_pick import hufd_pkg::*; #(
  parameter int N = GROUP_SIZE
) (
  input  logic [N-1:0]      hit,
  input  logic [N-1:0][7:0] sym,
  output logic              any_hit,
  output logic [7:0]        first_sym
);

  // Walk from the top down so the lowest index overrides
  always_comb begin
    any_hit   = 1'b0;
    first_sym = 8'd0;
    for (int i = N - 1; i >= 0; i--) begin
      if (hit[i]) begin
        any_hit   = 1'b1;
        first_sym = sym[i];
      end
    end
  end

endmodule

// File: bench/huffman_table_decoder_test.sv
// Self-checking testbench for huffman_table_decoder: fills the whole code table, runs
// directed and random load/decode/clear traffic and checks every result strobe.
// Depends on hufd_pkg and the huffman_table_decoder RTL only.
module huffman_table_decoder_test import hufd_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOT_COUNT    = 256;
  localparam int MAX_BITS      = 16;
  localparam int CANON_CODES   = 17;   // lengths 1..15 once, length 16 twice
  localparam int CANON_STRIDE  = 15;   // canonical codes sit in slots 0, 15, 30, ...
  localparam int PHASE_ITEMS   = 47;
  localparam int SETTLE_CYCLES = 50;
  localparam int TIMEOUT_NS    = 5_000_000;
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;

  // Scoreboard: own copy of the table and accumulator, queue of expected symbols
  class symbol_scoreboard;
    cell_entry_t         code_slots [SLOT_COUNT];
    logic [MAX_BITS-1:0] acc_bits;
    int unsigned         acc_len;
    result_t             expected_symbols [$];
    int unsigned         mismatches;

    function new();
      acc_bits   = '0;
      acc_len    = 0;
      mismatches = 0;
    endfunction

    // Lowest used slot whose length and masked code equal the accumulator
    function int lowest_match();
      logic [31:0] mask;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        if (code_slots[i].length == 0 || code_slots[i].length > MAX_BITS) continue;
        if (code_slots[i].length != acc_len) continue;
        mask = (32'd1 << code_slots[i].length) - 32'd1;
        if ((32'(code_slots[i].code) & mask) == 32'(acc_bits)) return i;
      end
      return -1;
    endfunction

    // Update state for an accepted transaction and queue the symbols it yields
    function void accept_request(request_t req);
      int unsigned nbits;
      int          hit;
      result_t     held;
      bit          have_held;
      case (req.req_type)
        REQ_LOAD: begin
          if (req.entry_index < SLOT_COUNT)
            code_slots[req.entry_index] = {req.entry_symbol, req.entry_code, req.entry_length};
        end
        REQ_CLEAR: begin
          acc_bits = '0;
          acc_len  = 0;
        end
        REQ_DECODE: begin
          nbits     = (req.bit_count > 8) ? 8 : req.bit_count;
          have_held = 1'b0;
          held      = '0;
          for (int b = 0; b < nbits; b++) begin
            acc_bits = {acc_bits[MAX_BITS-2:0], req.code_byte[7-b]};
            acc_len++;
            hit = lowest_match();
            if (hit >= 0 || acc_len >= MAX_BITS) begin
              // hold back one result so the last one can carry the end mark
              if (have_held) expected_symbols.push_back(held);
              held.symbol       = (hit >= 0) ? code_slots[hit].symbol : 8'd0;
              held.overflow     = (hit < 0);
              held.last_of_item = 1'b0;
              have_held         = 1'b1;
              acc_bits          = '0;
              acc_len           = 0;
            end
          end
          if (have_held) begin
            held.last_of_item = 1'b1;
            expected_symbols.push_back(held);
          end
        end
        default: ;
      endcase
    endfunction

    // Compare one result strobe against the oldest expectation
    function void check_result(result_t got);
      result_t want;
      if (expected_symbols.size() == 0) begin
        $error("unexpected result: symbol %0d overflow %0d last_of_item %0d",
               got.symbol, got.overflow, got.last_of_item);
        mismatches++;
        return;
      end
      want = expected_symbols.pop_front();
      if (got.symbol !== want.symbol) begin
        $error("symbol: expected %0d, actual %0d", want.symbol, got.symbol);
        mismatches++;
      end
      if (got.overflow !== want.overflow) begin
        $error("overflow: expected %0d, actual %0d", want.overflow, got.overflow);
        mismatches++;
      end
      if (got.last_of_item !== want.last_of_item) begin
        $error("last_of_item: expected %0d, actual %0d", want.last_of_item, got.last_of_item);
        mismatches++;
      end
    endfunction
  endclass

  logic     clk;
  logic     rst;
  logic     start;
  logic     busy;
  request_t request;
  logic     valid;
  result_t  result;

  symbol_scoreboard symbols = new();

  huffman_table_decoder #(
    .TABLE_ENTRIES(SLOT_COUNT),
    .MAX_CODE_LEN (MAX_BITS)
  ) u_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .request(request),
    .valid  (valid),
    .result (result)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Result monitor
  always @(posedge clk) begin
    if (!rst && valid) symbols.check_result(result);
  end

  // Transaction builders; fields the request type ignores stay random
  function automatic request_t noise_request();
    logic [63:0] raw;
    raw = {$urandom(), $urandom()};
    return raw[$bits(request_t)-1:0];
  endfunction

  function automatic request_t load_req(logic [7:0] idx, logic [7:0] sym,
                                        logic [15:0] code, logic [4:0] len);
    request_t r;
    r              = noise_request();
    r.req_type     = REQ_LOAD;
    r.entry_index  = idx;
    r.entry_symbol = sym;
    r.entry_code   = code;
    r.entry_length = len;
    return r;
  endfunction

  function automatic request_t decode_req(logic [7:0] bits, logic [3:0] count);
    request_t r;
    r           = noise_request();
    r.req_type  = REQ_DECODE;
    r.code_byte = bits;
    r.bit_count = count;
    return r;
  endfunction

  function automatic request_t plain_req(logic [1:0] kind);
    request_t r;
    r          = noise_request();
    r.req_type = kind;
    return r;
  endfunction

  // Complete prefix code: length L < 16 is L-1 ones then a zero, plus two 16-bit codes.
  // Bits above the length are random and must be ignored.
  function automatic request_t canon_entry(int j, logic [7:0] sym);
    logic [4:0]  len;
    logic [15:0] code;
    logic [31:0] high;
    len = (j < 15) ? 5'(j + 1) : 5'd16;
    if (j < 15) code = 16'((32'd1 << len) - 32'd2);
    else        code = (j == 15) ? 16'hFFFE : 16'hFFFF;
    high = $urandom() << len;
    if (len < 16) code = code | high[15:0];
    return load_req(8'(j * CANON_STRIDE), sym, code, len);
  endfunction

  // Present one transaction and wait until the block takes it
  task automatic send_request(input request_t r);
    @(negedge clk);
    start   <= 1'b1;
    request <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    symbols.accept_request(r);
  endtask

  task automatic hold_off(input int cycles);
    @(negedge clk);
    start <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  initial begin
    logic       stream_bits [$];
    int         used [$];
    int         pick;
    int         count;
    int         roll;
    int         idle_pct;
    logic [7:0] data_bits;

    start   = 1'b0;
    request = '0;
    rst     = 1'b1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Fill every slot: canonical codes plus unused or over-long junk
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (i % CANON_STRIDE == 0 && i / CANON_STRIDE < CANON_CODES)
        send_request(canon_entry(i / CANON_STRIDE, 8'($urandom())));
      else
        send_request(load_req(8'(i), 8'($urandom()), 16'($urandom()),
                              ($urandom_range(0, 3) == 0) ? 5'd0
                                                          : 5'($urandom_range(17, 31))));
    end

    // Directed: zero and oversized counts, unknown request, clears
    send_request(decode_req(8'hA5, 4'd0));
    send_request(plain_req(REQ_UNKNOWN));
    send_request(decode_req(8'h00, 4'd8));     // eight one-bit symbols
    send_request(decode_req(8'hFF, 4'd15));    // count above eight takes eight bits
    send_request(decode_req(8'hFF, 4'd8));     // sixteen ones hit the longest code
    send_request(decode_req(8'hC0, 4'd2));
    send_request(plain_req(REQ_CLEAR));
    send_request(decode_req(8'h40, 4'd2));
    send_request(plain_req(REQ_CLEAR));
    // lower slot with high garbage bits shadows the canonical two-bit code
    send_request(load_req(8'd1, 8'h5A, 16'hBEEE, 5'd2));
    send_request(decode_req(8'h80, 4'd2));
    // remove the all-ones code so sixteen ones overflow
    send_request(load_req(8'd240, 8'h77, 16'hFFFF, 5'd0));
    send_request(decode_req(8'hFF, 4'd8));
    send_request(decode_req(8'hFF, 4'd8));
    // overflow in the middle of a byte, then decoding goes on
    send_request(decode_req(8'hFF, 4'd4));
    send_request(decode_req(8'hFF, 4'd8));
    send_request(decode_req(8'hF0, 4'd8));
    send_request(canon_entry(16, 8'hC3));
    // length beyond the maximum never matches, even when its low bits would
    send_request(load_req(8'd4, 8'hE1, 16'h0006, 5'd19));
    send_request(decode_req(8'hC0, 4'd3));
    send_request(decode_req(8'h7F, 4'd8));
    send_request(plain_req(REQ_CLEAR));
    send_request(load_req(8'd255, 8'hFF, 16'hFFFF, 5'd31));
    send_request(load_req(8'd254, 8'h00, 16'h0000, 5'd0));

    // Random traffic in three idle phases: idle sparse, idle heavy, none
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 8 : (phase == 1) ? 64 : 0;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (idle_pct > 0 && $urandom_range(1, 100) <= idle_pct)
          hold_off($urandom_range(1, 12));
        roll = $urandom_range(0, 99);
        if (roll < 62) begin
          // well-formed stream: concatenated codes of used slots
          used.delete();
          for (int i = 0; i < SLOT_COUNT; i++)
            if (symbols.code_slots[i].length != 0 && symbols.code_slots[i].length <= MAX_BITS)
              used.push_back(i);
          if (used.size() == 0) begin
            send_request(decode_req(8'($urandom()), 4'($urandom_range(0, 15))));
          end else begin
            while (stream_bits.size() < 8) begin
              pick = used[$urandom_range(0, used.size() - 1)];
              for (int b = symbols.code_slots[pick].length - 1; b >= 0; b--)
                stream_bits.push_back(symbols.code_slots[pick].code[b]);
            end
            if ($urandom_range(0, 9) == 0) count = $urandom_range(9, 15);
            else                           count = $urandom_range(1, 8);
            data_bits = 8'($urandom());
            for (int b = 0; b < count && b < 8; b++)
              data_bits[7-b] = stream_bits.pop_front();
            send_request(decode_req(data_bits, 4'(count)));
          end
        end else if (roll < 70) begin
          send_request(decode_req(8'($urandom()), 4'($urandom_range(0, 15))));
        end else if (roll < 76) begin
          stream_bits.delete();
          send_request(plain_req(REQ_CLEAR));
        end else if (roll < 86) begin
          send_request(canon_entry($urandom_range(0, CANON_CODES - 1), 8'($urandom())));
        end else if (roll < 95) begin
          send_request(load_req(8'($urandom()), 8'($urandom()), 16'($urandom()),
                                5'($urandom_range(0, 31))));
        end else begin
          send_request(plain_req(REQ_UNKNOWN));
        end
      end
    end

    @(negedge clk);
    start <= 1'b0;

    // Drain, then watch for stray results
    while (symbols.expected_symbols.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (symbols.mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// File: files.f
hdl/hufd_pkg.sv
hdl/hufd_cell.sv
hdl/hufd_pick.sv
hdl/huffman_table_decoder.sv
bench/huffman_table_decoder_test.sv
